FILE: rtl/core/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types, constants and cofactor operand table for the small matrix
// inverse block.
// ----------------------------------------------------------------------------
package smi_pkg;

   localparam int IN_WIDTH_DEF  = 16;
   localparam int OUT_WIDTH_DEF = 32;
   localparam int FRAC_IN       = 12;
   localparam int FRAC_OUT      = 16;
   localparam int NUM_ELEM      = 9;
   localparam int NUM_ROW       = 3;

   typedef logic [1:0] dim_type;

   localparam dim_type DIM_ONE   = 2'd1;
   localparam dim_type DIM_TWO   = 2'd2;
   localparam dim_type DIM_THREE = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SINGULAR  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef logic [3:0] idx_type;

   // adjugate entry k = row*3+col is e[op0]*e[op1] - e[op2]*e[op3], e flat row*3+col
   localparam idx_type COF_OP [NUM_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd7, 4'd5},
      '{4'd7, 4'd2, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd4, 4'd2},
      '{4'd6, 4'd5, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd6, 4'd2},
      '{4'd3, 4'd2, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd6, 4'd4},
      '{4'd6, 4'd1, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd3, 4'd1}
   };

   typedef struct packed {
      logic    det_neg;
      logic    det_zero;
      dim_type dim;
   } ctl_type;

endpackage

FILE: rtl/core/small_matrix_inverse.sv
// ----------------------------------------------------------------------------
// small_matrix_inverse
// Determinant and inverse of a 1x1, 2x2 or 3x3 Q4.12 matrix by cofactors,
// results in Q16.16 with saturation and a singular/saturated status.
//
//   channel   ports             direction   moves
//   req       req_valid/ready   in          one matrix word
//   rsp       rsp_valid/ready   out         determinant, inverse, status word
//   csr       csr_valid/ready   in          dimension write (0 is ignored)
//
// One matrix per cycle sustained; the restoring divider in each of the nine
// lanes forms one quotient bit per stage. The whole pipeline holds while a
// result waits on rsp_ready.
// Synchronous active-high reset clears valid state and sets dimension to 3.
// ----------------------------------------------------------------------------
module small_matrix_inverse #(
   parameter int IN_WIDTH  = smi_pkg::IN_WIDTH_DEF,
   parameter int OUT_WIDTH = smi_pkg::OUT_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [IN_WIDTH-1:0]  req_a_r0_c0,
   input  logic signed [IN_WIDTH-1:0]  req_a_r0_c1,
   input  logic signed [IN_WIDTH-1:0]  req_a_r0_c2,
   input  logic signed [IN_WIDTH-1:0]  req_a_r1_c0,
   input  logic signed [IN_WIDTH-1:0]  req_a_r1_c1,
   input  logic signed [IN_WIDTH-1:0]  req_a_r1_c2,
   input  logic signed [IN_WIDTH-1:0]  req_a_r2_c0,
   input  logic signed [IN_WIDTH-1:0]  req_a_r2_c1,
   input  logic signed [IN_WIDTH-1:0]  req_a_r2_c2,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_WIDTH-1:0] rsp_determinant,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r0_c0,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r0_c1,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r0_c2,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r1_c0,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r1_c1,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r1_c2,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r2_c0,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r2_c1,
   output logic signed [OUT_WIDTH-1:0] rsp_inv_r2_c2,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_data
);

   localparam int CW = 2 * IN_WIDTH + 1;
   localparam int DW = 3 * IN_WIDTH + 3;
   localparam int QB = OUT_WIDTH + 1;
   localparam int NE = smi_pkg::NUM_ELEM;

   logic                       adv;
   smi_pkg::dim_type           dim_ff;
   smi_pkg::dim_type           dim_in;
   logic signed [IN_WIDTH-1:0] elem [NE];

   logic                       fe_valid;
   logic signed [CW-1:0]       fe_adj [NE];
   logic signed [DW-1:0]       fe_det;
   smi_pkg::dim_type           fe_dim;
   logic [DW-1:0]              det_mag;
   smi_pkg::ctl_type           ctl;

   logic                       side_valid_ff [QB+1];
   smi_pkg::ctl_type           side_ctl_ff [QB+1];
   logic [DW-1:0]              side_mag_ff [QB+1];

   logic [OUT_WIDTH:0]         lane_quot [NE];
   logic                       lane_ovf [NE];
   logic                       lane_neg [NE];
   logic signed [OUT_WIDTH-1:0] inv [NE];
   smi_pkg::status_type        status;

   // everything moves together unless a finished word is stuck at the output
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_comb begin
      dim_in = dim_ff;
      if (csr_valid && csr_data != '0) begin
         dim_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= smi_pkg::DIM_THREE;
      end else begin
         dim_ff <= dim_in;
      end
   end

   assign elem[0] = req_a_r0_c0;
   assign elem[1] = req_a_r0_c1;
   assign elem[2] = req_a_r0_c2;
   assign elem[3] = req_a_r1_c0;
   assign elem[4] = req_a_r1_c1;
   assign elem[5] = req_a_r1_c2;
   assign elem[6] = req_a_r2_c0;
   assign elem[7] = req_a_r2_c1;
   assign elem[8] = req_a_r2_c2;

   smi_cofactor #(
      .IN_WIDTH (IN_WIDTH)
   ) u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_elem   (elem),
      .in_dim    (dim_ff),
      .out_valid (fe_valid),
      .out_adj   (fe_adj),
      .out_det   (fe_det),
      .out_dim   (fe_dim)
   );

   always_comb begin
      det_mag      = fe_det[DW-1] ? DW'(-fe_det) : DW'(fe_det);
      ctl.det_neg  = fe_det[DW-1];
      ctl.det_zero = (fe_det == '0);
      ctl.dim      = fe_dim;
   end

   // side line keeps determinant and control aligned with the lane dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) begin
            side_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         side_valid_ff[0] <= fe_valid;
         for (int k = 1; k <= QB; k++) begin
            side_valid_ff[k] <= side_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ctl_ff[0] <= ctl;
         side_mag_ff[0] <= det_mag;
         for (int k = 1; k <= QB; k++) begin
            side_ctl_ff[k] <= side_ctl_ff[k-1];
            side_mag_ff[k] <= side_mag_ff[k-1];
         end
      end
   end

   for (genvar g = 0; g < NE; g++) begin : g_lane
      smi_div_lane #(
         .IN_WIDTH  (IN_WIDTH),
         .OUT_WIDTH (OUT_WIDTH)
      ) u_lane (
         .clock      (clock),
         .adv        (adv),
         .in_adj     (fe_adj[g]),
         .in_det_mag (det_mag),
         .in_det_neg (ctl.det_neg),
         .out_quot   (lane_quot[g]),
         .out_ovf    (lane_ovf[g]),
         .out_neg    (lane_neg[g])
      );
   end

   smi_merge #(
      .IN_WIDTH  (IN_WIDTH),
      .OUT_WIDTH (OUT_WIDTH)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (side_valid_ff[QB]),
      .in_ctl     (side_ctl_ff[QB]),
      .in_det_mag (side_mag_ff[QB]),
      .in_quot    (lane_quot),
      .in_ovf     (lane_ovf),
      .in_neg     (lane_neg),
      .out_valid  (rsp_valid),
      .out_det    (rsp_determinant),
      .out_inv    (inv),
      .out_status (status)
   );

   assign rsp_inv_r0_c0 = inv[0];
   assign rsp_inv_r0_c1 = inv[1];
   assign rsp_inv_r0_c2 = inv[2];
   assign rsp_inv_r1_c0 = inv[3];
   assign rsp_inv_r1_c1 = inv[4];
   assign rsp_inv_r1_c2 = inv[5];
   assign rsp_inv_r2_c0 = inv[6];
   assign rsp_inv_r2_c1 = inv[7];
   assign rsp_inv_r2_c2 = inv[8];
   assign rsp_status    = status;

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == smi_pkg::STATUS_SINGULAR |->
         rsp_determinant == '0 && rsp_inv_r0_c0 == '0 && rsp_inv_r2_c2 == '0)
      else $error("singular result carries nonzero values");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   a_dim_nonzero: assert property (@(posedge clock) disable iff (reset)
      dim_ff != '0)
      else $error("dimension register holds zero");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

FILE: rtl/core/smi_cofactor.sv
// ----------------------------------------------------------------------------
// smi_cofactor
// Front end: registers the matrix, forms minors, cofactors and determinant
// over five pipeline stages.
// ----------------------------------------------------------------------------
module smi_cofactor #(
   parameter int IN_WIDTH = smi_pkg::IN_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [IN_WIDTH-1:0]          in_elem [smi_pkg::NUM_ELEM],
   input  smi_pkg::dim_type                    in_dim,
   output logic                                out_valid,
   output logic signed [2*IN_WIDTH:0]          out_adj [smi_pkg::NUM_ELEM],
   output logic signed [3*IN_WIDTH+2:0]        out_det,
   output smi_pkg::dim_type                    out_dim
);

   localparam int PW = 2 * IN_WIDTH;
   localparam int CW = 2 * IN_WIDTH + 1;
   localparam int DW = 3 * IN_WIDTH + 3;
   localparam int NE = smi_pkg::NUM_ELEM;
   localparam int NR = smi_pkg::NUM_ROW;

   logic [4:0] valid_ff;

   logic signed [IN_WIDTH-1:0] s1_elem_ff [NE];
   smi_pkg::dim_type           s1_dim_ff;

   logic signed [PW-1:0]       s2_prod_ff [NE][2];
   logic signed [PW-1:0]       s2_prod_in [NE][2];
   logic signed [IN_WIDTH-1:0] s2_elem_ff [NE];
   smi_pkg::dim_type           s2_dim_ff;

   logic signed [CW-1:0]       s3_adj_ff [NE];
   logic signed [CW-1:0]       s3_adj_in [NE];
   logic signed [CW-1:0]       s3_m22_ff;
   logic signed [CW-1:0]       s3_m22_in;
   logic signed [IN_WIDTH-1:0] s3_row_ff [NR];
   smi_pkg::dim_type           s3_dim_ff;

   logic signed [DW-1:0]       s4_prod_ff [NR];
   logic signed [DW-1:0]       s4_prod_in [NR];
   logic signed [CW-1:0]       s4_adj_ff [NE];
   logic signed [CW-1:0]       s4_m22_ff;
   logic signed [IN_WIDTH-1:0] s4_a00_ff;
   smi_pkg::dim_type           s4_dim_ff;

   logic signed [DW-1:0]       s5_det_ff;
   logic signed [DW-1:0]       s5_det_in;
   logic signed [CW-1:0]       s5_adj_ff [NE];
   smi_pkg::dim_type           s5_dim_ff;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         s2_prod_in[k][0] = s1_elem_ff[smi_pkg::COF_OP[k][0]]
                          * s1_elem_ff[smi_pkg::COF_OP[k][1]];
         s2_prod_in[k][1] = s1_elem_ff[smi_pkg::COF_OP[k][2]]
                          * s1_elem_ff[smi_pkg::COF_OP[k][3]];
      end
   end

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         s3_adj_in[k] = '0;
      end
      s3_m22_in = CW'(s2_prod_ff[NE-1][0]) - CW'(s2_prod_ff[NE-1][1]);
      unique case (s2_dim_ff)
         smi_pkg::DIM_ONE: begin
            s3_adj_in[0] = CW'(1);
         end
         smi_pkg::DIM_TWO: begin
            s3_adj_in[0] = CW'(s2_elem_ff[4]);
            s3_adj_in[1] = -CW'(s2_elem_ff[1]);
            s3_adj_in[3] = -CW'(s2_elem_ff[3]);
            s3_adj_in[4] = CW'(s2_elem_ff[0]);
         end
         default: begin
            for (int k = 0; k < NE; k++) begin
               s3_adj_in[k] = CW'(s2_prod_ff[k][0]) - CW'(s2_prod_ff[k][1]);
            end
         end
      endcase
   end

   // expansion along row 0 uses the first column of the adjugate
   always_comb begin
      for (int j = 0; j < NR; j++) begin
         s4_prod_in[j] = DW'(s3_row_ff[j]) * DW'(s3_adj_ff[j*NR]);
      end
   end

   always_comb begin
      unique case (s4_dim_ff)
         smi_pkg::DIM_ONE: s5_det_in = DW'(s4_a00_ff);
         smi_pkg::DIM_TWO: s5_det_in = DW'(s4_m22_ff);
         default:          s5_det_in = s4_prod_ff[0] + s4_prod_ff[1] + s4_prod_ff[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_elem_ff <= in_elem;
         s1_dim_ff  <= in_dim;
         s2_prod_ff <= s2_prod_in;
         s2_elem_ff <= s1_elem_ff;
         s2_dim_ff  <= s1_dim_ff;
         s3_adj_ff  <= s3_adj_in;
         s3_m22_ff  <= s3_m22_in;
         for (int j = 0; j < NR; j++) begin
            s3_row_ff[j] <= s2_elem_ff[j];
         end
         s3_dim_ff  <= s2_dim_ff;
         s4_prod_ff <= s4_prod_in;
         s4_adj_ff  <= s3_adj_ff;
         s4_m22_ff  <= s3_m22_ff;
         s4_a00_ff  <= s3_row_ff[0];
         s4_dim_ff  <= s3_dim_ff;
         s5_det_ff  <= s5_det_in;
         s5_adj_ff  <= s4_adj_ff;
         s5_dim_ff  <= s4_dim_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_adj   = s5_adj_ff;
   assign out_det   = s5_det_ff;
   assign out_dim   = s5_dim_ff;

endmodule

FILE: rtl/core/smi_div_lane.sv
// ----------------------------------------------------------------------------
// smi_div_lane
// One lane: pipelined restoring divider forming cofactor over determinant
// in the output format, one quotient bit per stage.
// ----------------------------------------------------------------------------
module smi_div_lane #(
   parameter int IN_WIDTH  = smi_pkg::IN_WIDTH_DEF,
   parameter int OUT_WIDTH = smi_pkg::OUT_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic signed [2*IN_WIDTH:0]  in_adj,
   input  logic [3*IN_WIDTH+2:0]       in_det_mag,
   input  logic                        in_det_neg,
   output logic [OUT_WIDTH:0]          out_quot,
   output logic                        out_ovf,
   output logic                        out_neg
);

   localparam int CW   = 2 * IN_WIDTH + 1;
   localparam int AW   = 2 * IN_WIDTH;
   localparam int DW   = 3 * IN_WIDTH + 3;
   localparam int FSH  = smi_pkg::FRAC_IN + smi_pkg::FRAC_OUT;
   localparam int QB   = OUT_WIDTH + 1;
   localparam int NW   = (AW + FSH > QB) ? AW + FSH : QB + 1;
   localparam int HW   = NW - QB;
   localparam int CMPW = ((HW > DW) ? HW : DW) + 1;

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [QB-1:0] nlo;
      logic [QB-1:0] quot;
      logic [DW-1:0] dvs;
      logic          ovf;
      logic          neg;
   } stage_type;

   stage_type stage_ff [QB+1];
   stage_type stage_in [QB+1];

   logic [AW-1:0] adj_mag;
   logic [NW-1:0] num;
   logic [HW-1:0] num_hi;

   always_comb begin
      adj_mag = in_adj[CW-1] ? AW'(-in_adj) : AW'(in_adj);
      num     = NW'(adj_mag) << FSH;
      num_hi  = num[NW-1:QB];
   end

   always_comb begin
      logic [DW:0] trial;
      logic        take;
      // upper numerator bits at or above the divisor mean the quotient overflows
      stage_in[0].rem  = DW'(num_hi);
      stage_in[0].nlo  = num[QB-1:0];
      stage_in[0].quot = '0;
      stage_in[0].dvs  = in_det_mag;
      stage_in[0].ovf  = CMPW'(num_hi) >= CMPW'(in_det_mag);
      stage_in[0].neg  = in_adj[CW-1] ^ in_det_neg;
      for (int k = 0; k < QB; k++) begin
         trial = {stage_ff[k].rem, stage_ff[k].nlo[QB-1]};
         take  = trial >= {1'b0, stage_ff[k].dvs};
         stage_in[k+1]      = stage_ff[k];
         stage_in[k+1].rem  = take ? DW'(trial - {1'b0, stage_ff[k].dvs}) : DW'(trial);
         stage_in[k+1].nlo  = stage_ff[k].nlo << 1;
         stage_in[k+1].quot = {stage_ff[k].quot[QB-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_quot = stage_ff[QB].quot;
   assign out_ovf  = stage_ff[QB].ovf;
   assign out_neg  = stage_ff[QB].neg;

endmodule

FILE: rtl/core/smi_merge.sv
// ----------------------------------------------------------------------------
// smi_merge
// Merging stage: scales the determinant, saturates lane quotients, masks
// unused entries and builds the status into the output register.
// ----------------------------------------------------------------------------
module smi_merge #(
   parameter int IN_WIDTH  = smi_pkg::IN_WIDTH_DEF,
   parameter int OUT_WIDTH = smi_pkg::OUT_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  smi_pkg::ctl_type             in_ctl,
   input  logic [3*IN_WIDTH+2:0]        in_det_mag,
   input  logic [OUT_WIDTH:0]           in_quot [smi_pkg::NUM_ELEM],
   input  logic                         in_ovf [smi_pkg::NUM_ELEM],
   input  logic                         in_neg [smi_pkg::NUM_ELEM],
   output logic                         out_valid,
   output logic signed [OUT_WIDTH-1:0]  out_det,
   output logic signed [OUT_WIDTH-1:0]  out_inv [smi_pkg::NUM_ELEM],
   output smi_pkg::status_type          out_status
);

   localparam int DW  = 3 * IN_WIDTH + 3;
   localparam int QB  = OUT_WIDTH + 1;
   localparam int DSW = DW + smi_pkg::FRAC_OUT - smi_pkg::FRAC_IN;
   localparam int CMW = ((DSW > QB) ? DSW : QB) + 1;
   localparam int NE  = smi_pkg::NUM_ELEM;
   localparam int NR  = smi_pkg::NUM_ROW;

   logic                        valid_ff;
   logic signed [OUT_WIDTH-1:0] det_ff;
   logic signed [OUT_WIDTH-1:0] det_in;
   logic signed [OUT_WIDTH-1:0] inv_ff [NE];
   logic signed [OUT_WIDTH-1:0] inv_in [NE];
   smi_pkg::status_type         status_ff;
   smi_pkg::status_type         status_in;

   // result bit OUT_WIDTH flags saturation
   function automatic logic [OUT_WIDTH:0] clamp_out(input logic neg,
                                                    input logic [CMW-1:0] mag);
      logic [CMW-1:0]   lim;
      logic [OUT_WIDTH:0] res;
      lim = CMW'(1) << (OUT_WIDTH - 1);
      if (neg) begin
         if (mag > lim) res = {1'b1, OUT_WIDTH'(lim)};
         else           res = {1'b0, OUT_WIDTH'(-mag)};
      end else begin
         if (mag > lim - CMW'(1)) res = {1'b1, OUT_WIDTH'(lim - CMW'(1))};
         else                     res = {1'b0, OUT_WIDTH'(mag)};
      end
      return res;
   endfunction

   always_comb begin
      logic [DSW-1:0]     det_sh;
      logic [OUT_WIDTH:0] res;
      logic [CMW-1:0]     lane_mag;
      logic               sat_any;
      logic               used;
      unique case (in_ctl.dim)
         smi_pkg::DIM_ONE:
            det_sh = DSW'(in_det_mag) << (smi_pkg::FRAC_OUT - smi_pkg::FRAC_IN);
         smi_pkg::DIM_TWO:
            det_sh = DSW'(in_det_mag >> (2 * smi_pkg::FRAC_IN - smi_pkg::FRAC_OUT));
         default:
            det_sh = DSW'(in_det_mag >> (3 * smi_pkg::FRAC_IN - smi_pkg::FRAC_OUT));
      endcase
      res     = clamp_out(in_ctl.det_neg, CMW'(det_sh));
      det_in  = res[OUT_WIDTH-1:0];
      sat_any = res[OUT_WIDTH];
      for (int k = 0; k < NE; k++) begin
         used     = (2'(k / NR) < in_ctl.dim) && (2'(k % NR) < in_ctl.dim);
         lane_mag = in_ovf[k] ? {CMW{1'b1}} : CMW'(in_quot[k]);
         res      = clamp_out(in_neg[k], lane_mag);
         inv_in[k] = used ? res[OUT_WIDTH-1:0] : '0;
         sat_any   = sat_any | (used & res[OUT_WIDTH]);
      end
      if (in_ctl.det_zero) begin
         det_in    = '0;
         for (int k = 0; k < NE; k++) begin
            inv_in[k] = '0;
         end
         status_in = smi_pkg::STATUS_SINGULAR;
      end else if (sat_any) begin
         status_in = smi_pkg::STATUS_SATURATED;
      end else begin
         status_in = smi_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff    <= det_in;
         inv_ff    <= inv_in;
         status_ff <= status_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_det    = det_ff;
   assign out_inv    = inv_ff;
   assign out_status = status_ff;

endmodule
